### hdl/mmor_pkg.sv
// Shared types, status codes and defaults for the memory map overlap resolver.
package mmor_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 32;

  localparam logic [1:0] STATUS_REGION   = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_SINGLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_APPLY,
    S_PIECE,
    S_FINISH,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_t;

  typedef struct packed {
    logic load_we;
    logic sweep_init;
    logic cmp_en;
    logic apply_en;
    logic piece_en;
    logic out_load_res;
    logic out_load_single;
    logic out_load_empty;
    logic out_load_overflow;
  } cmd_t;

  typedef struct packed {
    logic best_found;
    logic overflow;
    logic emitted_zero;
    logic last;
  } status_t;

endpackage

### hdl/mmor_ctrl.sv
// Controller state machine: load, sweep sequencing and result delivery.
module mmor_ctrl #(
  parameter int unsigned CAPACITY = mmor_pkg::CAPACITY_DEFAULT,
  parameter int unsigned IDX_W    = $clog2(CAPACITY),
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1),
  parameter int unsigned EV_W     = $clog2(2 * CAPACITY)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 region_valid,
  input  logic                 final_region,
  output logic                 region_stall,
  output logic                 result_valid,
  input  logic                 result_stall,
  input  mmor_pkg::status_t    st,
  output mmor_pkg::cmd_t       cmd,
  output logic [IDX_W-1:0]     load_addr,
  output logic [IDX_W-1:0]     region_rd_addr,
  output logic [EV_W-1:0]      ev_idx,
  output logic [IDX_W-1:0]     res_idx
);

  mmor_pkg::state_t state, state_next;
  logic [CNT_W-1:0] load_count;
  logic [CNT_W:0]   ev_last_w;
  logic             ev_at_last;
  logic             room;

  assign room       = load_count < CNT_W'(CAPACITY);
  assign ev_last_w  = {load_count, 1'b0} - 1'b1;
  assign ev_at_last = ev_idx == ev_last_w[EV_W-1:0];
  assign load_addr  = load_count[IDX_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      mmor_pkg::S_LOAD: begin
        if (region_valid && final_region) state_next = mmor_pkg::S_START;
      end
      mmor_pkg::S_START: begin
        if (load_count == CNT_W'(1)) state_next = mmor_pkg::S_SINGLE;
        else if (load_count == '0) state_next = mmor_pkg::S_OUT_WAIT;
        else state_next = mmor_pkg::S_SCAN_RD;
      end
      mmor_pkg::S_SINGLE:   state_next = mmor_pkg::S_OUT_WAIT;
      mmor_pkg::S_SCAN_RD:  state_next = mmor_pkg::S_SCAN_CMP;
      mmor_pkg::S_SCAN_CMP: begin
        state_next = ev_at_last ? mmor_pkg::S_APPLY : mmor_pkg::S_SCAN_RD;
      end
      mmor_pkg::S_APPLY: begin
        state_next = st.best_found ? mmor_pkg::S_PIECE : mmor_pkg::S_FINISH;
      end
      mmor_pkg::S_PIECE: begin
        state_next = st.overflow ? mmor_pkg::S_OUT_WAIT : mmor_pkg::S_SCAN_RD;
      end
      mmor_pkg::S_FINISH: begin
        state_next = st.emitted_zero ? mmor_pkg::S_OUT_WAIT : mmor_pkg::S_OUT_RD;
      end
      mmor_pkg::S_OUT_RD: state_next = mmor_pkg::S_OUT_LD;
      mmor_pkg::S_OUT_LD: state_next = mmor_pkg::S_OUT_WAIT;
      mmor_pkg::S_OUT_WAIT: begin
        if (!result_stall) state_next = st.last ? mmor_pkg::S_LOAD : mmor_pkg::S_OUT_RD;
      end
      default: state_next = mmor_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    region_stall = 1'b1;
    result_valid = 1'b0;
    region_rd_addr = ev_idx[EV_W-1:1];
    case (state)
      mmor_pkg::S_LOAD: begin
        region_stall = 1'b0;
        cmd.load_we  = region_valid && room;
      end
      mmor_pkg::S_START: begin
        region_rd_addr = '0;
        cmd.sweep_init = 1'b1;
        cmd.out_load_empty = load_count == '0;
      end
      mmor_pkg::S_SINGLE:   cmd.out_load_single = 1'b1;
      mmor_pkg::S_SCAN_CMP: cmd.cmp_en = 1'b1;
      mmor_pkg::S_APPLY:    cmd.apply_en = st.best_found;
      mmor_pkg::S_PIECE: begin
        cmd.piece_en = 1'b1;
        cmd.out_load_overflow = st.overflow;
      end
      mmor_pkg::S_FINISH:   cmd.out_load_empty = st.emitted_zero;
      mmor_pkg::S_OUT_LD:   cmd.out_load_res = 1'b1;
      mmor_pkg::S_OUT_WAIT: result_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mmor_pkg::S_LOAD;
      load_count <= '0;
      ev_idx     <= '0;
      res_idx    <= '0;
    end else begin
      state <= state_next;
      if (cmd.load_we) load_count <= load_count + 1'b1;
      if (state == mmor_pkg::S_SCAN_CMP && !ev_at_last) ev_idx <= ev_idx + 1'b1;
      if (state == mmor_pkg::S_APPLY || state == mmor_pkg::S_START) ev_idx <= '0;
      if (state == mmor_pkg::S_FINISH) res_idx <= '0;
      if (state == mmor_pkg::S_OUT_WAIT && !result_stall) begin
        if (st.last) load_count <= '0;
        else res_idx <= res_idx + 1'b1;
      end
    end
  end

endmodule

### hdl/mmor_datapath.sv
// Datapath: region store, event selection, open-kind counters, piece builder, result buffer.
module mmor_datapath #(
  parameter int unsigned CAPACITY = mmor_pkg::CAPACITY_DEFAULT,
  parameter int unsigned IDX_W    = $clog2(CAPACITY),
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1),
  parameter int unsigned EV_W     = $clog2(2 * CAPACITY)
) (
  input  logic               clk,
  input  logic               rst,
  input  mmor_pkg::cmd_t     cmd,
  output mmor_pkg::status_t  st,
  input  logic [IDX_W-1:0]   load_addr,
  input  logic [IDX_W-1:0]   region_rd_addr,
  input  logic [EV_W-1:0]    ev_idx,
  input  logic [IDX_W-1:0]   res_idx,
  input  logic [63:0]        region_base,
  input  logic [63:0]        region_length,
  input  logic [3:0]         region_kind,
  input  logic [31:0]        region_attributes,
  output logic [63:0]        out_base,
  output logic [63:0]        out_length,
  output logic [3:0]         out_kind,
  output logic [31:0]        out_attributes,
  output logic [1:0]         result_status
);

  localparam int unsigned KEY_W = 64 + 1 + EV_W;

  // Region store; the end address and a usable flag are worked out at load time.
  logic [63:0] mem_base [CAPACITY];
  logic [63:0] mem_len  [CAPACITY];
  logic [63:0] mem_end  [CAPACITY];
  logic [3:0]  mem_kind [CAPACITY];
  logic [31:0] mem_attr [CAPACITY];
  logic        mem_ok   [CAPACITY];

  logic [63:0] rd_base, rd_len, rd_end;
  logic [3:0]  rd_kind;
  logic [31:0] rd_attr;
  logic        rd_ok;

  logic [64:0] load_sum;
  assign load_sum = {1'b0, region_base} + {1'b0, region_length};

  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      mem_base[load_addr] <= region_base;
      mem_len[load_addr]  <= region_length;
      mem_end[load_addr]  <= load_sum[63:0];
      mem_kind[load_addr] <= region_kind;
      mem_attr[load_addr] <= region_attributes;
      mem_ok[load_addr]   <= !load_sum[64] && (region_length != '0);
    end
    rd_base <= mem_base[region_rd_addr];
    rd_len  <= mem_len[region_rd_addr];
    rd_end  <= mem_end[region_rd_addr];
    rd_kind <= mem_kind[region_rd_addr];
    rd_attr <= mem_attr[region_rd_addr];
    rd_ok   <= mem_ok[region_rd_addr];
  end

  // Next event: smallest key above the previous one. Ends sort before starts.
  logic             is_start;
  logic [KEY_W-1:0] cand_key, prev_key, best_key;
  logic             prev_valid, best_found;
  logic [3:0]       best_kind;
  logic [31:0]      best_attr;
  logic             take;

  assign is_start = !ev_idx[0];
  assign cand_key = {(is_start ? rd_base : rd_end), !is_start ? 1'b0 : 1'b1, ev_idx};
  assign take = rd_ok && (!prev_valid || cand_key > prev_key) &&
                (!best_found || cand_key < best_key);

  // One counter of open regions per kind replaces the open set.
  logic [CNT_W-1:0] kind_cnt [16];
  logic [3:0]       cur;
  logic [63:0]      ev_addr;
  logic [63:0]      piece_start;
  logic [3:0]       piece_kind;
  logic [31:0]      piece_attr;
  logic [CNT_W-1:0] emitted;
  logic             emit;

  always_comb begin
    cur = '0;
    for (int k = 1; k < 16; k++) begin
      if (kind_cnt[k] != '0) cur = 4'(k);
    end
  end

  assign ev_addr = prev_key[KEY_W-1:KEY_W-64];
  assign emit = (cur != piece_kind) && (piece_kind != '0) && (ev_addr != piece_start);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
      best_found <= 1'b0;
      piece_kind <= '0;
      emitted    <= '0;
      for (int k = 0; k < 16; k++) kind_cnt[k] <= '0;
    end else begin
      if (cmd.sweep_init) begin
        prev_valid <= 1'b0;
        best_found <= 1'b0;
        piece_kind <= '0;
        emitted    <= '0;
        for (int k = 0; k < 16; k++) kind_cnt[k] <= '0;
      end
      if (cmd.cmp_en && take) best_found <= 1'b1;
      if (cmd.apply_en) begin
        prev_valid <= 1'b1;
        if (best_key[EV_W]) kind_cnt[best_kind] <= kind_cnt[best_kind] + 1'b1;
        else kind_cnt[best_kind] <= kind_cnt[best_kind] - 1'b1;
      end
      if (cmd.piece_en) begin
        best_found <= 1'b0;
        if (emit) emitted <= emitted + 1'b1;
        if (cur != piece_kind) piece_kind <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_en && take) begin
      best_key  <= cand_key;
      best_kind <= rd_kind;
      best_attr <= rd_attr;
    end
    if (cmd.apply_en) prev_key <= best_key;
    if (cmd.piece_en && cur != piece_kind && cur != '0) begin
      piece_start <= ev_addr;
      piece_attr  <= best_attr;
    end
  end

  // Result buffer.
  logic [63:0] res_base [CAPACITY];
  logic [63:0] res_len  [CAPACITY];
  logic [3:0]  res_kind [CAPACITY];
  logic [31:0] res_attr [CAPACITY];
  logic [63:0] rr_base, rr_len;
  logic [3:0]  rr_kind;
  logic [31:0] rr_attr;

  always_ff @(posedge clk) begin
    if (cmd.piece_en && emit) begin
      res_base[emitted[IDX_W-1:0]] <= piece_start;
      res_len[emitted[IDX_W-1:0]]  <= ev_addr - piece_start;
      res_kind[emitted[IDX_W-1:0]] <= piece_kind;
      res_attr[emitted[IDX_W-1:0]] <= piece_attr;
    end
    rr_base <= res_base[res_idx];
    rr_len  <= res_len[res_idx];
    rr_kind <= res_kind[res_idx];
    rr_attr <= res_attr[res_idx];
  end

  // Output register, held while the receiver stalls.
  logic out_last;
  logic [CNT_W:0] res_next;
  assign res_next = {1'b0, CNT_W'(res_idx)} + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.out_load_res) begin
      out_base       <= rr_base;
      out_length     <= rr_len;
      out_kind       <= rr_kind;
      out_attributes <= rr_attr;
      result_status  <= mmor_pkg::STATUS_REGION;
      out_last       <= res_next == {1'b0, emitted};
    end else if (cmd.out_load_single) begin
      out_base       <= rd_base;
      out_length     <= rd_len;
      out_kind       <= rd_kind;
      out_attributes <= rd_attr;
      result_status  <= mmor_pkg::STATUS_REGION;
      out_last       <= 1'b1;
    end else if (cmd.out_load_empty || cmd.out_load_overflow) begin
      out_base       <= '0;
      out_length     <= '0;
      out_kind       <= '0;
      out_attributes <= '0;
      result_status  <= cmd.out_load_overflow ? mmor_pkg::STATUS_OVERFLOW
                                              : mmor_pkg::STATUS_EMPTY;
      out_last       <= 1'b1;
    end
  end

  assign st.best_found   = best_found;
  assign st.overflow     = emit && (emitted == CNT_W'(CAPACITY - 1));
  assign st.emitted_zero = emitted == '0;
  assign st.last         = out_last;

endmodule

### hdl/memory_map_overlap_resolver_unit.sv
// Memory map overlap resolver: stores regions, then sweeps them into disjoint pieces.
//
// Input channel: region_valid / region_stall carry one region per request. Regions
// load at one per cycle while the unit is collecting; past CAPACITY they are dropped.
// A request with final_region set closes the map and starts resolution; region_stall
// stays high until every result of that map has been taken.
// Output channel: result_valid / result_stall carry one resolved region per request,
// with last_result on the final one. A lone region comes back unchanged; an empty
// sweep gives one map-empty result; too many pieces give one overflow result.
// Sweep: the unit picks each next event by scanning all 2N events of the N stored
// regions, each through a read state and a compare state on the region store's read
// port; each result then passes through a buffer read and an output load. Each result
// waits in the output register for as long as the receiver stalls.
// Reset returns the unit to collecting with an empty map; store contents are not
// cleared, since every entry is written before it is read.
module memory_map_overlap_resolver_unit #(
  parameter int unsigned CAPACITY = mmor_pkg::CAPACITY_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        region_valid,
  output logic        region_stall,
  input  logic [63:0] region_base,
  input  logic [63:0] region_length,
  input  logic [3:0]  region_kind,
  input  logic [31:0] region_attributes,
  input  logic        final_region,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [63:0] out_base,
  output logic [63:0] out_length,
  output logic [3:0]  out_kind,
  output logic [31:0] out_attributes,
  output logic [1:0]  result_status,
  output logic        last_result
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned EV_W  = $clog2(2 * CAPACITY);

  mmor_pkg::cmd_t    cmd;
  mmor_pkg::status_t st;
  logic [IDX_W-1:0]  load_addr, region_rd_addr, res_idx;
  logic [EV_W-1:0]   ev_idx;

  assign last_result = st.last;

  mmor_ctrl #(
    .CAPACITY(CAPACITY), .IDX_W(IDX_W), .CNT_W(CNT_W), .EV_W(EV_W)
  ) u_ctrl (
    .clk(clk), .rst(rst),
    .region_valid(region_valid), .final_region(final_region),
    .region_stall(region_stall),
    .result_valid(result_valid), .result_stall(result_stall),
    .st(st), .cmd(cmd),
    .load_addr(load_addr), .region_rd_addr(region_rd_addr),
    .ev_idx(ev_idx), .res_idx(res_idx)
  );

  mmor_datapath #(
    .CAPACITY(CAPACITY), .IDX_W(IDX_W), .CNT_W(CNT_W), .EV_W(EV_W)
  ) u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .load_addr(load_addr), .region_rd_addr(region_rd_addr),
    .ev_idx(ev_idx), .res_idx(res_idx),
    .region_base(region_base), .region_length(region_length),
    .region_kind(region_kind), .region_attributes(region_attributes),
    .out_base(out_base), .out_length(out_length), .out_kind(out_kind),
    .out_attributes(out_attributes), .result_status(result_status)
  );

endmodule
